@@ sv/sie_pkg.sv @@
// Package: shared constants, types and codes of the sorted-list intersection block.
`timescale 1ns / 1ps

package sie_pkg;

  // Sizing
  localparam int MAX_LISTS  = 8;
  localparam int LIST_DEPTH = 1024;
  localparam int ENT_W      = 32;
  localparam int LIST_W     = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
  localparam int CNT_W      = $clog2(MAX_LISTS + 1);
  localparam int ADDR_W     = LIST_W + IDX_W;
  localparam int MEM_DEPTH  = 2 ** ADDR_W;

  // Configuration register indexes
  localparam logic CFG_REQUIRED = 1'b0;
  localparam logic CFG_EXCLUDED = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_MATCH   = 3'd1;
  localparam logic [2:0] ST_NOMATCH = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_ORDER   = 3'd4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_REWIND = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       list_select;
    logic [ENT_W-1:0] entity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ENT_W-1:0] match_entity;
  } out_item_t;

  // Classified command held in the queue between front and back
  typedef struct packed {
    op_t              op;
    logic             sel_ok;
    logic [LIST_W-1:0] list;
    logic [ENT_W-1:0] entity;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SEEK_INIT,
    S_SEEK_ISSUE,
    S_SEEK_WAIT,
    S_CHK_ISSUE,
    S_CHK_WAIT,
    S_EXC_ISSUE,
    S_EXC_WAIT,
    S_BUMP,
    S_RESP
  } st_t;

endpackage

@@ sv/sie_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module sie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sie_front.sv @@
// Front end: accepts input items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module sie_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sie_pkg::in_item_t in_item,
  output logic              head_vld,
  output sie_pkg::cmd_t     head,
  input  logic              pop
);

  sie_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  sie_pkg::cmd_t cmd;
  logic          push;

  // Decode opcode and range-check the list number
  always_comb begin
    cmd.op     = sie_pkg::op_t'(in_item.opcode);
    cmd.sel_ok = {29'd0, in_item.list_select} < 32'(sie_pkg::MAX_LISTS);
    cmd.list   = sie_pkg::LIST_W'(in_item.list_select);
    cmd.entity = in_item.entity;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign head_vld = (cnt_r != 2'd0);
  assign head     = mem_r[rp_r];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ sv/sie_back.sv @@
// Back end: executes queued commands against the list memory and drives results.
`timescale 1ns / 1ps

module sie_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata,
  input  logic               head_vld,
  input  sie_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sie_pkg::out_item_t out_item
);

  localparam int LW = sie_pkg::LIST_W;
  localparam int NW = sie_pkg::LEN_W;
  localparam int CW = sie_pkg::CNT_W;
  localparam int EW = sie_pkg::ENT_W;
  localparam int IW = sie_pkg::IDX_W;

  sie_pkg::st_t       state_r, state_nxt;
  logic [NW-1:0]      len_r  [sie_pkg::MAX_LISTS];
  logic [NW-1:0]      len_nxt[sie_pkg::MAX_LISTS];
  logic [NW-1:0]      cur_r  [sie_pkg::MAX_LISTS];
  logic [NW-1:0]      cur_nxt[sie_pkg::MAX_LISTS];
  logic [EW-1:0]      last_r [sie_pkg::MAX_LISTS];
  logic [EW-1:0]      last_nxt[sie_pkg::MAX_LISTS];
  logic [EW-1:0]      tgt_r, tgt_nxt;
  logic [NW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               found_r, found_nxt;
  sie_pkg::cmd_t      cmd_r, cmd_nxt;
  sie_pkg::out_item_t res_r, res_nxt, out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         req_r;
  logic [2:0]         exc_r;

  logic [31:0]        req_w, room_w, exc_w;
  logic [CW-1:0]      req_eff, end_eff;
  logic [LW-1:0]      li;
  logic [NW-1:0]      mid;
  logic               seek_last, cur_end, out_free;
  logic               app_full, app_order;
  logic [NW-1:0]      app_len;
  logic               ram_we;
  logic [sie_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_rdata;

  sie_ram #(
    .WIDTH(EW),
    .DEPTH(sie_pkg::MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd_r.entity),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Effective counts: required at least one and clamped to the list count, excluded clamped to the lists left over
  always_comb begin
    if (req_r == 4'd0) begin
      req_w = 32'd1;
    end else if ({28'd0, req_r} > 32'(sie_pkg::MAX_LISTS)) begin
      req_w = 32'(sie_pkg::MAX_LISTS);
    end else begin
      req_w = {28'd0, req_r};
    end
    room_w  = 32'(sie_pkg::MAX_LISTS) - req_w;
    exc_w   = ({29'd0, exc_r} > room_w) ? room_w : {29'd0, exc_r};
    req_eff = CW'(req_w);
    end_eff = CW'(req_w + exc_w);
  end

  assign li        = idx_r[LW-1:0];
  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign seek_last = (idx_r == CW'(sie_pkg::MAX_LISTS - 1));
  assign cur_end   = (cur_r[li] >= len_r[li]);
  assign out_free  = !out_valid_r || !out_stall;
  assign app_len   = len_r[cmd_r.list];
  assign app_full  = !cmd_r.sel_ok || (app_len >= NW'(sie_pkg::LIST_DEPTH));
  assign app_order = (app_len != '0) && (cmd_r.entity < last_r[cmd_r.list]);

  // Memory ports
  assign ram_we    = (state_r == sie_pkg::S_EXEC) && (cmd_r.op == sie_pkg::OP_APPEND)
                     && !app_full && !app_order;
  assign ram_waddr = {cmd_r.list, app_len[IW-1:0]};
  assign ram_raddr = (state_r == sie_pkg::S_SEEK_ISSUE) ? {li, mid[IW-1:0]}
                                                        : {li, cur_r[li][IW-1:0]};

  assign pop       = (state_r == sie_pkg::S_IDLE) && head_vld;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sie_pkg::S_IDLE:       if (head_vld) state_nxt = sie_pkg::S_EXEC;
      sie_pkg::S_EXEC: begin
        state_nxt = (cmd_r.op == sie_pkg::OP_QUERY) ? sie_pkg::S_SEEK_INIT : sie_pkg::S_RESP;
      end
      sie_pkg::S_SEEK_INIT:  state_nxt = sie_pkg::S_SEEK_ISSUE;
      sie_pkg::S_SEEK_ISSUE: begin
        if (lo_r < hi_r)    state_nxt = sie_pkg::S_SEEK_WAIT;
        else if (seek_last) state_nxt = sie_pkg::S_CHK_ISSUE;
        else                state_nxt = sie_pkg::S_SEEK_INIT;
      end
      sie_pkg::S_SEEK_WAIT:  state_nxt = sie_pkg::S_SEEK_ISSUE;
      sie_pkg::S_CHK_ISSUE: begin
        if (idx_r == req_eff) begin
          state_nxt = found_r ? sie_pkg::S_EXC_ISSUE : sie_pkg::S_SEEK_INIT;
        end else if (cur_end) begin
          state_nxt = sie_pkg::S_RESP;
        end else begin
          state_nxt = sie_pkg::S_CHK_WAIT;
        end
      end
      sie_pkg::S_CHK_WAIT:   state_nxt = sie_pkg::S_CHK_ISSUE;
      sie_pkg::S_EXC_ISSUE: begin
        if (idx_r == end_eff) state_nxt = found_r ? sie_pkg::S_RESP : sie_pkg::S_BUMP;
        else if (!cur_end)    state_nxt = sie_pkg::S_EXC_WAIT;
      end
      sie_pkg::S_EXC_WAIT:   state_nxt = sie_pkg::S_EXC_ISSUE;
      sie_pkg::S_BUMP:       state_nxt = sie_pkg::S_SEEK_INIT;
      sie_pkg::S_RESP:       if (out_free) state_nxt = sie_pkg::S_IDLE;
      default:               state_nxt = sie_pkg::S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    tgt_nxt       = tgt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      sie_pkg::S_IDLE: begin
        if (head_vld) cmd_nxt = head;
      end
      sie_pkg::S_EXEC: begin
        res_nxt = '{status: sie_pkg::ST_DONE, match_entity: '0};
        unique case (cmd_r.op)
          sie_pkg::OP_APPEND: begin
            if (app_full) begin
              res_nxt.status = sie_pkg::ST_FULL;
            end else if (app_order) begin
              res_nxt.status = sie_pkg::ST_ORDER;
            end else begin
              len_nxt[cmd_r.list]  = app_len + NW'(1);
              last_nxt[cmd_r.list] = cmd_r.entity;
            end
          end
          sie_pkg::OP_CLEAR: begin
            for (int k = 0; k < sie_pkg::MAX_LISTS; k++) begin
              len_nxt[k] = '0;
              cur_nxt[k] = '0;
            end
          end
          sie_pkg::OP_REWIND: begin
            for (int k = 0; k < sie_pkg::MAX_LISTS; k++) cur_nxt[k] = '0;
          end
          sie_pkg::OP_QUERY: begin
            tgt_nxt = cmd_r.entity;
            idx_nxt = '0;
          end
          default: ;
        endcase
      end
      sie_pkg::S_SEEK_INIT: begin
        lo_nxt = cur_r[li];
        hi_nxt = len_r[li];
      end
      sie_pkg::S_SEEK_ISSUE: begin
        if (lo_r >= hi_r) begin
          cur_nxt[li] = lo_r;
          if (seek_last) begin
            idx_nxt   = '0;
            found_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      sie_pkg::S_SEEK_WAIT: begin
        if (ram_rdata < tgt_r) lo_nxt = mid + NW'(1);
        else                   hi_nxt = mid;
      end
      sie_pkg::S_CHK_ISSUE: begin
        if (idx_r == req_eff) begin
          if (!found_r) idx_nxt = '0;
        end else if (cur_end) begin
          res_nxt = '{status: sie_pkg::ST_NOMATCH, match_entity: '0};
        end
      end
      sie_pkg::S_CHK_WAIT: begin
        // A larger entry raises the target; only the first list keeps the round alive
        if (ram_rdata != tgt_r) begin
          if (ram_rdata > tgt_r) tgt_nxt = ram_rdata;
          found_nxt = (idx_r == '0);
        end
        idx_nxt = idx_r + CW'(1);
      end
      sie_pkg::S_EXC_ISSUE: begin
        if (idx_r == end_eff) begin
          if (found_r) res_nxt = '{status: sie_pkg::ST_MATCH, match_entity: tgt_r};
        end else if (cur_end) begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      sie_pkg::S_EXC_WAIT: begin
        if (ram_rdata == tgt_r) found_nxt = 1'b0;
        idx_nxt = idx_r + CW'(1);
      end
      sie_pkg::S_BUMP: begin
        for (int k = 0; k < sie_pkg::MAX_LISTS; k++) begin
          if (CW'(k) < req_eff) cur_nxt[k] = cur_r[k] + NW'(1);
        end
        idx_nxt   = '0;
        found_nxt = 1'b1;
      end
      sie_pkg::S_RESP: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    tgt_r   <= tgt_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    cmd_r   <= cmd_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    last_r  <= last_nxt;
    if (!rst_n) begin
      state_r     <= sie_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      req_r       <= 4'd1;
      exc_r       <= 3'd0;
      for (int k = 0; k < sie_pkg::MAX_LISTS; k++) begin
        len_r[k] <= '0;
        cur_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      if (cfg_we && cfg_index == sie_pkg::CFG_REQUIRED) req_r <= cfg_wdata;
      if (cfg_we && cfg_index == sie_pkg::CFG_EXCLUDED) exc_r <= cfg_wdata[2:0];
    end
  end

endmodule

@@ sv/sorted_intersect_with_exclusion.sv @@
// Top level: multiway sorted-list intersection with exclusion lists.
`timescale 1ns / 1ps

// Channel  | ports                          | payload
// ---------+--------------------------------+-------------------------------
// input    | in_valid, in_stall, in_item    | opcode, list_select, entity
// result   | out_valid, out_stall, out_item | status, match_entity
// config   | cfg_we, cfg_index, cfg_wdata   | required_count, excluded_count
//
// Append, clear and rewind run through S_IDLE, S_EXEC and S_RESP to the result.
// A query runs rounds over the single list memory read port: each round does a
// binary search on every list (up to LEN_W probes per list, each a read)
// and then reads each required and excluded list; the round count is data-dependent.
// Reset (synchronous, rst_n low) empties all lists and cursors; memory is not cleared.
// A two-entry queue takes items while the back end works or the result waits on out_stall.

module sorted_intersect_with_exclusion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sie_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sie_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata
);

  logic          q_vld, q_pop;
  sie_pkg::cmd_t q_head;

  sie_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .head_vld(q_vld),
    .head    (q_head),
    .pop     (q_pop)
  );

  sie_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .head_vld (q_vld),
    .head     (q_head),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Queue is only popped when it holds an item
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_vld)
    else $error("queue popped while empty");

  // Only a match carries an id
  a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != sie_pkg::ST_MATCH |-> out_item.match_entity == '0)
    else $error("nonzero id without match");

  // A popped item cannot produce a result in the very next cycle
  a_pop_latency: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !$rose(out_valid))
    else $error("result too early after pop");

endmodule

@@ verif/testbench.sv @@
// Testbench for the sorted-list intersection block: directed and random items against a predictor.
`timescale 1ns / 1ps

// Scoreboard: mirrors list state, predicts one result per accepted item, checks results
class intersect_scoreboard;
  logic [31:0] ids [sie_pkg::MAX_LISTS][$];
  int unsigned cur [sie_pkg::MAX_LISTS];
  int unsigned req_cnt;
  int unsigned exc_cnt;
  sie_pkg::out_item_t pending [$];
  int errors;

  function void clear_all();
    for (int l = 0; l < sie_pkg::MAX_LISTS; l++) begin
      ids[l].delete();
      cur[l] = 0;
    end
    req_cnt = 1;
    exc_cnt = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(logic idx, logic [3:0] val);
    if (idx == sie_pkg::CFG_REQUIRED) req_cnt = val;
    else exc_cnt = val[2:0];
  endfunction

  // Advance a cursor to the first id at or above key
  function void advance(int l, logic [31:0] key);
    while (cur[l] < ids[l].size() && ids[l][cur[l]] < key) cur[l]++;
  endfunction

  function bit search(logic [31:0] target, output logic [31:0] hit);
    int unsigned rq;
    int unsigned ex;
    bit ok;
    logic [31:0] v;
    rq = (req_cnt == 0) ? 1 : req_cnt;
    if (rq > sie_pkg::MAX_LISTS) rq = sie_pkg::MAX_LISTS;
    ex = exc_cnt;
    if (ex > sie_pkg::MAX_LISTS - rq) ex = sie_pkg::MAX_LISTS - rq;
    hit = '0;
    forever begin
      ok = 1;
      for (int l = 0; l < sie_pkg::MAX_LISTS; l++) advance(l, target);
      for (int l = 0; l < rq; l++) begin
        if (cur[l] >= ids[l].size()) return 0;
        v = ids[l][cur[l]];
        if (v != target) begin
          if (v > target) target = v;
          ok = (l == 0);
        end
      end
      if (ok) begin
        for (int l = rq; l < rq + ex; l++)
          if (cur[l] < ids[l].size() && ids[l][cur[l]] == target) ok = 0;
        if (ok) begin
          hit = target;
          return 1;
        end
        for (int l = 0; l < rq; l++) cur[l]++;
      end
    end
  endfunction

  function void note_item(sie_pkg::in_item_t it);
    sie_pkg::out_item_t r;
    logic [31:0] hit;
    r = '0;
    r.status = sie_pkg::ST_DONE;
    case (sie_pkg::op_t'(it.opcode))
      sie_pkg::OP_APPEND: begin
        if (ids[it.list_select].size() >= sie_pkg::LIST_DEPTH)
          r.status = sie_pkg::ST_FULL;
        else if (ids[it.list_select].size() > 0 &&
                 it.entity < ids[it.list_select][$])
          r.status = sie_pkg::ST_ORDER;
        else ids[it.list_select].push_back(it.entity);
      end
      sie_pkg::OP_CLEAR: begin
        for (int l = 0; l < sie_pkg::MAX_LISTS; l++) begin
          ids[l].delete();
          cur[l] = 0;
        end
      end
      sie_pkg::OP_REWIND: begin
        for (int l = 0; l < sie_pkg::MAX_LISTS; l++) cur[l] = 0;
      end
      default: begin
        if (search(it.entity, hit)) begin
          r.status = sie_pkg::ST_MATCH;
          r.match_entity = hit;
        end else r.status = sie_pkg::ST_NOMATCH;
      end
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(sie_pkg::out_item_t got);
    sie_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $error("unexpected result: status %0d match_entity %0h", got.status, got.match_entity);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.match_entity !== want.match_entity) begin
      $error("match_entity: expected %0h, actual %0h", want.match_entity, got.match_entity);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  sie_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  sie_pkg::out_item_t out_item;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [3:0] cfg_wdata = '0;

  int send_idle_pct = 20;
  int recv_idle_pct = 68;
  int hold_cycles = 0;
  logic [31:0] last_id [sie_pkg::MAX_LISTS];
  intersect_scoreboard sb;

  sorted_intersect_with_exclusion dut (.*);

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one item and wait until it is accepted; valid drops only while idling
  task automatic send_item(logic [1:0] op, logic [2:0] sel, logic [31:0] ent);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= '{opcode: op, list_select: sel, entity: ent};
    do @(posedge clk); while (in_stall);
    sb.note_item('{opcode: op, list_select: sel, entity: ent});
  endtask

  // Write a register once all results are in and the block has settled
  task automatic write_reg(logic idx, logic [3:0] val);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
  endtask

  // Append a non-decreasing id, mostly in a small shared range so lists overlap
  task automatic append_sorted(int l);
    logic [31:0] step;
    step = ($urandom_range(3) == 0) ? 0 : $urandom_range(4);
    if (last_id[l] > 32'hFFFF_FFF0) step = 0;
    last_id[l] = last_id[l] + step;
    send_item(sie_pkg::OP_APPEND, l[2:0], last_id[l]);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_item(sie_pkg::OP_CLEAR, 3'($urandom), $urandom);
        foreach (last_id[l]) last_id[l] = $urandom_range(20);
      end else if (r < 8) send_item(sie_pkg::OP_REWIND, 3'($urandom), $urandom);
      else if (r < 50) append_sorted($urandom_range(sie_pkg::MAX_LISTS - 1));
      else if (r < 55) send_item(sie_pkg::OP_APPEND, 3'($urandom), $urandom);
      else if (r < 95) send_item(sie_pkg::OP_QUERY, 3'($urandom), $urandom_range(120));
      else send_item(sie_pkg::OP_QUERY, 3'($urandom), $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    foreach (last_id[l]) last_id[l] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: ordering, equal ids, extremes, every operation
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd0);
    send_item(sie_pkg::OP_APPEND, 3'd0, 32'd5);
    send_item(sie_pkg::OP_APPEND, 3'd0, 32'd5);
    send_item(sie_pkg::OP_APPEND, 3'd0, 32'd3);
    send_item(sie_pkg::OP_APPEND, 3'd0, 32'hFFFF_FFFF);
    send_item(sie_pkg::OP_APPEND, 3'd1, 32'd5);
    send_item(sie_pkg::OP_APPEND, 3'd1, 32'hFFFF_FFFF);
    send_item(sie_pkg::OP_APPEND, 3'd7, 32'd0);
    send_item(sie_pkg::OP_APPEND, 3'd2, 32'd5);
    send_item(sie_pkg::OP_QUERY, 3'd7, 32'd0);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd6);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd0);
    send_item(sie_pkg::OP_REWIND, 3'd0, 32'd0);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'hFFFF_FFFF);
    write_reg(sie_pkg::CFG_REQUIRED, 4'd2);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd1);
    send_item(sie_pkg::OP_REWIND, 3'd0, 32'd0);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd0);
    write_reg(sie_pkg::CFG_REQUIRED, 4'd0);
    send_item(sie_pkg::OP_REWIND, 3'd0, 32'd0);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd0);
    write_reg(sie_pkg::CFG_REQUIRED, 4'd15);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd7);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd0);
    send_item(sie_pkg::OP_CLEAR, 3'd0, 32'd0);
    send_item(sie_pkg::OP_QUERY, 3'd0, 32'd0);

    // Random phases under different settings and idling patterns
    write_reg(sie_pkg::CFG_REQUIRED, 4'd1);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd0);
    random_phase(120);
    write_reg(sie_pkg::CFG_REQUIRED, 4'd2);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd2);
    hold_cycles = 300;
    random_phase(100);
    send_idle_pct = 68;
    recv_idle_pct = 20;
    write_reg(sie_pkg::CFG_REQUIRED, 4'd3);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd7);
    random_phase(110);
    write_reg(sie_pkg::CFG_REQUIRED, 4'd8);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd0);
    random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(sie_pkg::CFG_REQUIRED, 4'd1);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd7);
    random_phase(100);
    write_reg(sie_pkg::CFG_REQUIRED, 4'd2);
    write_reg(sie_pkg::CFG_EXCLUDED, 4'd1);
    random_phase(100);

    // Drain
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/sie_pkg.sv
sv/sie_ram.sv
sv/sie_front.sv
sv/sie_back.sv
sv/sorted_intersect_with_exclusion.sv
verif/testbench.sv
